// File: sv/sqhtc_pkg.sv
// Package for the stack/queue/heap trace classifier.
// Holds operation and verdict codes, the controller state and command types,
// and the status struct. No dependencies.
package sqhtc_pkg;

  localparam int DEFAULT_STORE_DEPTH = 1024;
  localparam int DEFAULT_VALUE_BITS  = 16;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  localparam logic [2:0] V_NOT_SURE   = 3'd0;
  localparam logic [2:0] V_STACK      = 3'd1;
  localparam logic [2:0] V_QUEUE      = 3'd2;
  localparam logic [2:0] V_PQ         = 3'd3;
  localparam logic [2:0] V_IMPOSSIBLE = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_HU_RD,
    ST_HU_CMP,
    ST_POP_CMP,
    ST_HD_LAST_RD,
    ST_HD_LAST,
    ST_HD_RD,
    ST_HD_CMP
  } state_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_LATCH,
    C_PUSH,
    C_HU_RD,
    C_HU_PLACE,
    C_HU_MOVE,
    C_POP_RD,
    C_POP_CMP,
    C_HD_LAST_RD,
    C_HD_LAST,
    C_HD_RD,
    C_HD_PLACE,
    C_HD_MOVE,
    C_END
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       out_full;
    logic       heap_room;
    logic       pos_zero;
    logic       parent_ge;
    logic       heap_hit;
    logic       heap_left;
    logic       child_end;
    logic       sift_stop;
  } status_t;

  // Two flags set name the store whose flag is clear.
  function automatic logic [2:0] verdict_of(input logic lb, input logic fb, input logic hb);
    logic [1:0] n;
    n = 2'(lb) + 2'(fb) + 2'(hb);
    if (n <= 2'd1) return V_NOT_SURE;
    if (n == 2'd3) return V_IMPOSSIBLE;
    if (!lb) return V_STACK;
    if (!fb) return V_QUEUE;
    return V_PQ;
  endfunction

endpackage

// File: sv/stack_queue_heap_trace_classifier.sv
// Trace classifier: checks push/pop items against a stack, a queue and a
// max-heap kept side by side, and names which of them fits the trace.
// Top level; instantiates sqhtc_ctrl and sqhtc_dp, uses sqhtc_pkg.
//
// Input channel: in_valid / in_stall with in_operation (push, pop, end of
// case) and in_value. Output channel: out_valid / out_stall with out_verdict
// and out_overflow; one result per end-of-case item, none for push or pop.
// Items are taken one at a time; the next is not accepted until the last is
// through. A push writes the stack and the queue, then, unless the heap is
// full, moves the value up the heap, one parent read and compare per level,
// until the parent is not smaller or the root is reached. A pop reads all
// three stores and compares; when the heap matched and still holds entries,
// the last heap entry is read and sifted down from the root, one read of the
// children and compare per level. An end of case loads the verdict and empties
// the stores. The worst case is set by the heap sift loops.
// The verdict sits in an output register; push and pop items keep flowing
// while it waits, and only the next end-of-case item is stalled until the
// receiver takes it. Synchronous reset empties all stores, clears the flags
// and drops any waiting result; the store contents need no clearing.
module stack_queue_heap_trace_classifier #(
  parameter int STORE_DEPTH = sqhtc_pkg::DEFAULT_STORE_DEPTH,
  parameter int VALUE_BITS  = sqhtc_pkg::DEFAULT_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_verdict,
  output logic        out_overflow
);

  sqhtc_pkg::cmd_t    cmd;
  sqhtc_pkg::status_t status;

  // Sequencer.
  sqhtc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Stores and result register.
  sqhtc_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_operation),
    .in_value     (in_value),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_verdict  (out_verdict),
    .out_overflow (out_overflow)
  );

endmodule

// File: sv/sqhtc_ctrl.sv
// Controller state machine of the trace classifier.
// Sequences push, pop and end-of-case commands; uses sqhtc_pkg.
module sqhtc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_operation,
  output logic               in_stall,
  input  sqhtc_pkg::status_t status,
  output sqhtc_pkg::cmd_t    cmd
);

  sqhtc_pkg::state_t state_r, state_nxt;

  // Stall while busy, and hold off an end-of-case item while the previous verdict still waits.
  assign in_stall = (state_r != sqhtc_pkg::ST_IDLE) ||
                    (status.out_full && in_operation == sqhtc_pkg::OP_END);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sqhtc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command.
  always_comb begin
    state_nxt = state_r;
    cmd       = sqhtc_pkg::C_NONE;
    unique case (state_r)
      sqhtc_pkg::ST_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd       = sqhtc_pkg::C_LATCH;
          state_nxt = sqhtc_pkg::ST_DISPATCH;
        end
      end
      sqhtc_pkg::ST_DISPATCH: begin
        unique case (status.op)
          sqhtc_pkg::OP_PUSH: begin
            cmd       = sqhtc_pkg::C_PUSH;
            state_nxt = status.heap_room ? sqhtc_pkg::ST_HU_RD : sqhtc_pkg::ST_IDLE;
          end
          sqhtc_pkg::OP_POP: begin
            cmd       = sqhtc_pkg::C_POP_RD;
            state_nxt = sqhtc_pkg::ST_POP_CMP;
          end
          sqhtc_pkg::OP_END: begin
            cmd       = sqhtc_pkg::C_END;
            state_nxt = sqhtc_pkg::ST_IDLE;
          end
          default: state_nxt = sqhtc_pkg::ST_IDLE;
        endcase
      end
      sqhtc_pkg::ST_HU_RD: begin
        if (status.pos_zero) begin
          cmd       = sqhtc_pkg::C_HU_PLACE;
          state_nxt = sqhtc_pkg::ST_IDLE;
        end else begin
          cmd       = sqhtc_pkg::C_HU_RD;
          state_nxt = sqhtc_pkg::ST_HU_CMP;
        end
      end
      sqhtc_pkg::ST_HU_CMP: begin
        if (status.parent_ge) begin
          cmd       = sqhtc_pkg::C_HU_PLACE;
          state_nxt = sqhtc_pkg::ST_IDLE;
        end else begin
          cmd       = sqhtc_pkg::C_HU_MOVE;
          state_nxt = sqhtc_pkg::ST_HU_RD;
        end
      end
      sqhtc_pkg::ST_POP_CMP: begin
        cmd       = sqhtc_pkg::C_POP_CMP;
        state_nxt = (status.heap_hit && status.heap_left) ?
                    sqhtc_pkg::ST_HD_LAST_RD : sqhtc_pkg::ST_IDLE;
      end
      sqhtc_pkg::ST_HD_LAST_RD: begin
        cmd       = sqhtc_pkg::C_HD_LAST_RD;
        state_nxt = sqhtc_pkg::ST_HD_LAST;
      end
      sqhtc_pkg::ST_HD_LAST: begin
        cmd       = sqhtc_pkg::C_HD_LAST;
        state_nxt = sqhtc_pkg::ST_HD_RD;
      end
      sqhtc_pkg::ST_HD_RD: begin
        if (status.child_end) begin
          cmd       = sqhtc_pkg::C_HD_PLACE;
          state_nxt = sqhtc_pkg::ST_IDLE;
        end else begin
          cmd       = sqhtc_pkg::C_HD_RD;
          state_nxt = sqhtc_pkg::ST_HD_CMP;
        end
      end
      sqhtc_pkg::ST_HD_CMP: begin
        if (status.sift_stop) begin
          cmd       = sqhtc_pkg::C_HD_PLACE;
          state_nxt = sqhtc_pkg::ST_IDLE;
        end else begin
          cmd       = sqhtc_pkg::C_HD_MOVE;
          state_nxt = sqhtc_pkg::ST_HD_RD;
        end
      end
      default: state_nxt = sqhtc_pkg::ST_IDLE;
    endcase
  end

  // Items are only taken from the idle state.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> state_r == sqhtc_pkg::ST_IDLE)
    else $error("item accepted while busy");
  // A sift-up compare always follows a parent read.
  a_hu_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sqhtc_pkg::ST_HU_CMP |-> $past(state_r) == sqhtc_pkg::ST_HU_RD)
    else $error("sift-up compare without read");
  // A sift-down compare always follows a child read.
  a_hd_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sqhtc_pkg::ST_HD_CMP |-> $past(state_r) == sqhtc_pkg::ST_HD_RD)
    else $error("sift-down compare without read");

endmodule

// File: sv/sqhtc_dp.sv
// Datapath of the trace classifier: the three stores, counts, flags and the
// result register. Executes commands from sqhtc_ctrl; uses sqhtc_pkg.
module sqhtc_dp #(
  parameter int STORE_DEPTH = sqhtc_pkg::DEFAULT_STORE_DEPTH,
  parameter int VALUE_BITS  = sqhtc_pkg::DEFAULT_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_operation,
  input  logic [15:0]        in_value,
  input  sqhtc_pkg::cmd_t    cmd,
  output sqhtc_pkg::status_t status,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_verdict,
  output logic               out_overflow
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int XW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  logic [VALUE_BITS-1:0] lifo_mem [STORE_DEPTH];
  logic [VALUE_BITS-1:0] fifo_mem [STORE_DEPTH];
  logic [VALUE_BITS-1:0] heap_mem [STORE_DEPTH];

  logic [1:0]            op_r;
  logic [VALUE_BITS-1:0] val_r, last_r;
  logic [CW-1:0]         lifo_count_r, fifo_count_r, heap_count_r;
  logic [AW-1:0]         fifo_head_r, pos_r;
  logic                  lifo_bad_r, fifo_bad_r, heap_bad_r, overflow_seen_r;
  logic                  out_valid_r, out_overflow_r;
  logic [2:0]            out_verdict_r;
  logic [VALUE_BITS-1:0] lifo_rd_r, fifo_rd_r, heap_rd_a_r, heap_rd_b_r;

  logic [31:0]           in_val32;
  logic [XW-1:0]         fifo_sum, child_x, childb_x;
  logic [AW-1:0]         fifo_tail, parent, lifo_top, child_a, child_b;
  logic                  childb_ok, lifo_hit, fifo_hit;
  logic [VALUE_BITS-1:0] sel_val;
  logic [AW-1:0]         sel_idx;

  logic                  heap_we, heap_re;
  logic [AW-1:0]         heap_wa, heap_ra_a, heap_ra_b;
  logic [VALUE_BITS-1:0] heap_wd;

  assign in_val32 = {16'd0, in_value};

  // Index arithmetic.
  assign fifo_sum  = XW'(fifo_head_r) + XW'(fifo_count_r);
  assign fifo_tail = (fifo_sum >= XW'(STORE_DEPTH)) ?
                     AW'(fifo_sum - XW'(STORE_DEPTH)) : AW'(fifo_sum);
  assign parent    = AW'((pos_r - AW'(1)) >> 1);
  assign lifo_top  = (lifo_count_r == '0) ? '0 : AW'(lifo_count_r - CW'(1));
  assign child_x   = XW'({pos_r, 1'b1});
  assign childb_x  = child_x + XW'(1);
  assign childb_ok = childb_x < XW'(heap_count_r);
  assign child_a   = AW'(child_x);
  assign child_b   = childb_ok ? AW'(childb_x) : child_a;
  assign sel_val   = (childb_ok && heap_rd_b_r > heap_rd_a_r) ? heap_rd_b_r : heap_rd_a_r;
  assign sel_idx   = (childb_ok && heap_rd_b_r > heap_rd_a_r) ? child_b : child_a;
  assign lifo_hit  = (lifo_count_r != '0) && (lifo_rd_r == val_r);
  assign fifo_hit  = (fifo_count_r != '0) && (fifo_rd_r == val_r);

  // Status to the controller.
  always_comb begin
    status.op        = op_r;
    status.out_full  = out_valid_r;
    status.heap_room = heap_count_r != DEPTH_C;
    status.pos_zero  = pos_r == '0;
    status.parent_ge = heap_rd_a_r >= val_r;
    status.heap_hit  = (heap_count_r != '0) && (heap_rd_a_r == val_r);
    status.heap_left = heap_count_r != CW'(1);
    status.child_end = child_x >= XW'(heap_count_r);
    status.sift_stop = sel_val <= last_r;
  end

  // Heap memory port control.
  always_comb begin
    heap_we   = 1'b0;
    heap_wa   = pos_r;
    heap_wd   = val_r;
    heap_re   = 1'b0;
    heap_ra_a = '0;
    heap_ra_b = '0;
    case (cmd)
      sqhtc_pkg::C_HU_PLACE: heap_we = 1'b1;
      sqhtc_pkg::C_HU_MOVE: begin
        heap_we = 1'b1;
        heap_wd = heap_rd_a_r;
      end
      sqhtc_pkg::C_HU_RD: begin
        heap_re   = 1'b1;
        heap_ra_a = parent;
      end
      sqhtc_pkg::C_POP_RD: heap_re = 1'b1;
      sqhtc_pkg::C_HD_LAST_RD: begin
        heap_re   = 1'b1;
        heap_ra_a = AW'(heap_count_r);
      end
      sqhtc_pkg::C_HD_RD: begin
        heap_re   = 1'b1;
        heap_ra_a = child_a;
        heap_ra_b = child_b;
      end
      sqhtc_pkg::C_HD_PLACE: begin
        heap_we = 1'b1;
        heap_wd = last_r;
      end
      sqhtc_pkg::C_HD_MOVE: begin
        heap_we = 1'b1;
        heap_wd = sel_val;
      end
      default: ;
    endcase
  end

  // Heap memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    if (heap_re) begin
      heap_rd_a_r <= heap_mem[heap_ra_a];
      heap_rd_b_r <= heap_mem[heap_ra_b];
    end
  end

  // Stack and queue memories.
  always_ff @(posedge clk) begin
    if (cmd == sqhtc_pkg::C_PUSH && lifo_count_r != DEPTH_C) begin
      lifo_mem[AW'(lifo_count_r)] <= val_r;
    end
    if (cmd == sqhtc_pkg::C_PUSH && fifo_count_r != DEPTH_C) begin
      fifo_mem[fifo_tail] <= val_r;
    end
    if (cmd == sqhtc_pkg::C_POP_RD) begin
      lifo_rd_r <= lifo_mem[lifo_top];
      fifo_rd_r <= fifo_mem[fifo_head_r];
    end
  end

  // Item payload and heap working registers.
  always_ff @(posedge clk) begin
    case (cmd)
      sqhtc_pkg::C_LATCH: begin
        op_r  <= in_operation;
        val_r <= in_val32[VALUE_BITS-1:0];
      end
      sqhtc_pkg::C_PUSH:       pos_r <= AW'(heap_count_r);
      sqhtc_pkg::C_HU_MOVE:    pos_r <= parent;
      sqhtc_pkg::C_HD_LAST_RD: pos_r <= '0;
      sqhtc_pkg::C_HD_LAST:    last_r <= heap_rd_a_r;
      sqhtc_pkg::C_HD_MOVE:    pos_r <= sel_idx;
      default: ;
    endcase
  end

  // Counts, flags and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifo_count_r    <= '0;
      fifo_count_r    <= '0;
      fifo_head_r     <= '0;
      heap_count_r    <= '0;
      lifo_bad_r      <= 1'b0;
      fifo_bad_r      <= 1'b0;
      heap_bad_r      <= 1'b0;
      overflow_seen_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        sqhtc_pkg::C_PUSH: begin
          if (lifo_count_r != DEPTH_C) lifo_count_r <= lifo_count_r + CW'(1);
          if (fifo_count_r != DEPTH_C) fifo_count_r <= fifo_count_r + CW'(1);
          if (heap_count_r != DEPTH_C) heap_count_r <= heap_count_r + CW'(1);
          if (lifo_count_r == DEPTH_C || fifo_count_r == DEPTH_C ||
              heap_count_r == DEPTH_C) begin
            overflow_seen_r <= 1'b1;
          end
        end
        sqhtc_pkg::C_POP_CMP: begin
          if (lifo_hit) lifo_count_r <= lifo_count_r - CW'(1);
          else lifo_bad_r <= 1'b1;
          if (fifo_hit) begin
            fifo_count_r <= fifo_count_r - CW'(1);
            fifo_head_r  <= (fifo_head_r == AW'(STORE_DEPTH - 1)) ? '0 : fifo_head_r + AW'(1);
          end else begin
            fifo_bad_r <= 1'b1;
          end
          if (status.heap_hit) heap_count_r <= heap_count_r - CW'(1);
          else heap_bad_r <= 1'b1;
        end
        sqhtc_pkg::C_END: begin
          out_valid_r     <= 1'b1;
          out_verdict_r   <= sqhtc_pkg::verdict_of(lifo_bad_r, fifo_bad_r, heap_bad_r);
          out_overflow_r  <= overflow_seen_r;
          lifo_count_r    <= '0;
          fifo_count_r    <= '0;
          fifo_head_r     <= '0;
          heap_count_r    <= '0;
          lifo_bad_r      <= 1'b0;
          fifo_bad_r      <= 1'b0;
          heap_bad_r      <= 1'b0;
          overflow_seen_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_verdict  = out_verdict_r;
  assign out_overflow = out_overflow_r;

  // Counts stay within the store depth.
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    lifo_count_r <= DEPTH_C && fifo_count_r <= DEPTH_C && heap_count_r <= DEPTH_C)
    else $error("store count beyond depth");
  // A verdict is never loaded over one that waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == sqhtc_pkg::C_END) |-> !out_valid_r)
    else $error("result overwritten");
  // End of case leaves the stack and the heap empty and the heap flag clear.
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == sqhtc_pkg::C_END) |=> (heap_count_r == '0 && lifo_count_r == '0 && !heap_bad_r))
    else $error("state not cleared at end of case");

endmodule

// File: dv/stack_queue_heap_trace_classifier_test.sv
// Self-checking testbench for the stack/queue/heap trace classifier.
// Drives push, pop and end-of-case items, predicts each verdict with its own
// stack, queue and max-heap model, and checks every result. Uses sqhtc_pkg.
`timescale 1ns / 1ps

module stack_queue_heap_trace_classifier_test;

  localparam int DEPTH      = 1024;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] value;
  } trace_item_t;

  typedef struct packed {
    logic [2:0] verdict;
    logic       overflow;
  } verdict_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [15:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_verdict;
  logic        out_overflow;

  trace_item_t pending_items[$];
  verdict_t    expected_verdicts[$];
  int          error_count;
  int          idle_cycles;
  bit          stimulus_done;
  bit          in_taken;

  // Predictor state: plain queues stand in for the three stores.
  logic [15:0] stack_model[$];
  logic [15:0] queue_model[$];
  logic [15:0] heap_model[$];
  bit          stack_bad, queue_bad, heap_bad, overflow_seen;

  stack_queue_heap_trace_classifier u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_verdict(out_verdict), .out_overflow(out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // The heap only needs its maximum; index of the largest entry.
  function automatic int heap_top_index();
    int best;
    best = 0;
    for (int i = 1; i < heap_model.size(); i++)
      if (heap_model[i] > heap_model[best]) best = i;
    return best;
  endfunction

  // Apply one accepted item to the model; queues an expectation on end of case.
  task automatic predict_trace_item(input trace_item_t item);
    int       top;
    int       n;
    verdict_t v;
    top = 0;
    case (item.op)
      sqhtc_pkg::OP_PUSH: begin
        if (stack_model.size() < DEPTH) stack_model.push_back(item.value);
        else overflow_seen = 1;
        if (queue_model.size() < DEPTH) queue_model.push_back(item.value);
        else overflow_seen = 1;
        if (heap_model.size() < DEPTH) heap_model.push_back(item.value);
        else overflow_seen = 1;
      end
      sqhtc_pkg::OP_POP: begin
        if (stack_model.size() == 0 || stack_model[$] != item.value) stack_bad = 1;
        else void'(stack_model.pop_back());
        if (queue_model.size() == 0 || queue_model[0] != item.value) queue_bad = 1;
        else void'(queue_model.pop_front());
        if (heap_model.size() != 0) top = heap_top_index();
        if (heap_model.size() == 0 || heap_model[top] != item.value) heap_bad = 1;
        else heap_model.delete(top);
      end
      sqhtc_pkg::OP_END: begin
        n = int'(stack_bad) + int'(queue_bad) + int'(heap_bad);
        if (n <= 1) v.verdict = sqhtc_pkg::V_NOT_SURE;
        else if (n == 3) v.verdict = sqhtc_pkg::V_IMPOSSIBLE;
        else if (!stack_bad) v.verdict = sqhtc_pkg::V_STACK;
        else if (!queue_bad) v.verdict = sqhtc_pkg::V_QUEUE;
        else v.verdict = sqhtc_pkg::V_PQ;
        v.overflow = overflow_seen;
        expected_verdicts.push_back(v);
        stack_model.delete();
        queue_model.delete();
        heap_model.delete();
        stack_bad = 0; queue_bad = 0; heap_bad = 0; overflow_seen = 0;
      end
      default: ;
    endcase
  endtask

  function automatic trace_item_t make_item(input logic [1:0] op, input logic [15:0] value);
    trace_item_t t;
    t.op = op;
    t.value = value;
    return t;
  endfunction

  // Builds one case that follows a given discipline, with some noise on top.
  // style 0 stack, 1 queue, 2 priority queue, 3 random.
  task automatic add_case(input int style, input int length, input int value_max);
    logic [15:0] live[$];
    logic [15:0] v;
    int          best;
    for (int i = 0; i < length; i++) begin
      if (live.size() == 0 || $urandom_range(1, 0) == 1) begin
        v = 16'($urandom_range(value_max, 0));
        live.push_back(v);
        pending_items.push_back(make_item(sqhtc_pkg::OP_PUSH, v));
      end else begin
        case (style)
          0: v = live.pop_back();
          1: v = live.pop_front();
          2: begin
            best = 0;
            foreach (live[k]) if (live[k] > live[best]) best = k;
            v = live[best];
            live.delete(best);
          end
          default: v = 16'($urandom_range(value_max, 0));
        endcase
        // An occasional wrong pop breaks the discipline.
        if ($urandom_range(30, 0) == 0) v = 16'($urandom);
        pending_items.push_back(make_item(sqhtc_pkg::OP_POP, v));
      end
    end
    if ($urandom_range(9, 0) == 0)
      pending_items.push_back(make_item(OP_UNUSED, 16'($urandom)));
    pending_items.push_back(make_item(sqhtc_pkg::OP_END, 16'($urandom)));
  endtask

  // Stimulus: directed cases first, then random traces.
  initial begin
    pending_items.push_back(make_item(sqhtc_pkg::OP_END, 16'hffff));   // empty case
    pending_items.push_back(make_item(sqhtc_pkg::OP_POP, 16'h0000));   // pop from empty
    pending_items.push_back(make_item(sqhtc_pkg::OP_END, 16'h0000));
    pending_items.push_back(make_item(sqhtc_pkg::OP_PUSH, 16'h0000));
    pending_items.push_back(make_item(sqhtc_pkg::OP_PUSH, 16'hffff));
    pending_items.push_back(make_item(OP_UNUSED, 16'h1234));           // unused code
    pending_items.push_back(make_item(sqhtc_pkg::OP_POP, 16'hffff));
    pending_items.push_back(make_item(sqhtc_pkg::OP_POP, 16'h0000));
    pending_items.push_back(make_item(sqhtc_pkg::OP_END, 16'h0000));   // stack or heap
    pending_items.push_back(make_item(sqhtc_pkg::OP_PUSH, 16'h5555));
    pending_items.push_back(make_item(sqhtc_pkg::OP_PUSH, 16'haaaa));
    pending_items.push_back(make_item(sqhtc_pkg::OP_POP, 16'h5555));
    pending_items.push_back(make_item(sqhtc_pkg::OP_POP, 16'haaaa));
    pending_items.push_back(make_item(sqhtc_pkg::OP_END, 16'h0000));   // queue
    pending_items.push_back(make_item(sqhtc_pkg::OP_PUSH, 16'h0001));
    pending_items.push_back(make_item(sqhtc_pkg::OP_POP, 16'h0002));
    pending_items.push_back(make_item(sqhtc_pkg::OP_POP, 16'h0001));
    pending_items.push_back(make_item(sqhtc_pkg::OP_END, 16'h0000));   // impossible
    // Overflow: fill the stores past their depth, then pop in heap order.
    for (int i = 0; i < DEPTH + 3; i++)
      pending_items.push_back(make_item(sqhtc_pkg::OP_PUSH, 16'(i)));
    for (int i = 0; i < 4; i++)
      pending_items.push_back(make_item(sqhtc_pkg::OP_POP, 16'(DEPTH - 1 - i)));
    pending_items.push_back(make_item(sqhtc_pkg::OP_END, 16'h0000));
    for (int c = 0; c < 56; c++)
      add_case($urandom_range(3, 0), $urandom_range(20, 1),
               ($urandom_range(1, 0) == 1) ? 15 : 65535);
    stimulus_done = 1;
  end

  // Records whether the item on the input was taken at the last rising edge.
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
  end

  // Driver: bursts of items with random gaps, changes on the falling edge.
  int burst_left;
  int gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // Hold the item until it is taken.
    end else begin
      if (in_valid) void'(pending_items.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_valid <= 1'b1;
        in_operation <= pending_items[0].op;
        in_value <= pending_items[0].value;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(12, 0);
          gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(4, 1);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: long free runs alternate with stalled stretches.
  int stall_phase;
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 64;
    out_stall <= (stall_phase >= 40) ? ($urandom_range(3, 0) != 0) : 1'b0;
  end

  // Monitor: predict on input acceptance, check on output acceptance.
  verdict_t got;
  verdict_t want;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall) begin
        predict_trace_item(make_item(in_operation, in_value));
      end
      if (out_valid && !out_stall) begin
        got.verdict = out_verdict;
        got.overflow = out_overflow;
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict with none expected");
        end else begin
          want = expected_verdicts.pop_front();
          if (got.verdict !== want.verdict)
            report_mismatch($sformatf("verdict %0d, expected %0d", got.verdict, want.verdict));
          if (got.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %0b, expected %0b",
                                      got.overflow, want.overflow));
        end
      end
    end
  end

  // Reset, completion and watchdog.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = sqhtc_pkg::OP_PUSH;
    in_value = 16'h0000;
    out_stall = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    stall_phase = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (!(stimulus_done && pending_items.size() == 0 && !in_valid &&
             expected_verdicts.size() == 0) && idle_cycles < IDLE_LIMIT)
      @(posedge clk);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
    end else begin
      repeat (50) @(posedge clk);
      if (error_count == 0 && expected_verdicts.size() == 0 && !out_valid) begin
        $display("TB_OK");
      end else begin
        $display("TB_ERROR");
      end
    end
    $finish;
  end

endmodule
